// File: rtl/gamepad_edge_repeat_tracker_assert.svh
// Assertion macros used by the checker file.
`ifndef GAMEPAD_EDGE_REPEAT_TRACKER_ASSERT_SVH
`define GAMEPAD_EDGE_REPEAT_TRACKER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define GERT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one at the next clock edge.
`define GERT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gert_pkg.sv
// Shared widths, codes and helper functions of the gamepad edge and repeat tracker.
package gert_pkg;

	localparam int unsigned BUTTON_W = 17;
	localparam int unsigned AXIS_W = 8;
	localparam int unsigned THR_W = 7;
	localparam int unsigned HOLD_W = 32;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned NBITS = 25;
	localparam int unsigned MASK_W = 27;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = HOLD_W;

	localparam int unsigned BIT_CIRCLE = 5;
	localparam int unsigned BIT_CROSS = 6;
	localparam int unsigned BIT_HOME = 16;

	localparam logic [CNT_W-1:0] REPEAT_FIRE = CNT_W'(10);
	localparam logic [CNT_W-1:0] FAST_RELOAD = CNT_W'(6);

	localparam logic [AXIS_W-1:0] CENTER_RST = AXIS_W'(128);
	localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(64);
	localparam logic [HOLD_W-1:0] HOME_HOLD_RST = HOLD_W'(1000000);

	typedef enum logic [1:0] {
		HOME_NONE = 2'd0,
		HOME_ENABLE = 2'd1,
		HOME_DISABLE = 2'd2
	} home_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_ENTER_CIRCLE = 2'd2,
		REG_HOME_HOLD = 2'd3
	} cfg_reg_t;

	// {high, low} direction bits of one stick axis
	function automatic logic [1:0] axis_bits(input logic [AXIS_W-1:0] x,
			input logic [AXIS_W-1:0] c, input logic [THR_W-1:0] t);
		logic [AXIS_W:0] x_plus_t;
		logic [AXIS_W:0] c_plus_t;
		logic lo;
		logic hi;
		x_plus_t = {1'b0, x} + {{(AXIS_W+1-THR_W){1'b0}}, t};
		c_plus_t = {1'b0, c} + {{(AXIS_W+1-THR_W){1'b0}}, t};
		lo = x_plus_t < {1'b0, c};
		hi = !lo && ({1'b0, x} > c_plus_t);
		return {hi, lo};
	endfunction

	// Append enter and cancel copied from circle and cross
	function automatic logic [MASK_W-1:0] add_mirror(input logic [NBITS-1:0] m,
			input logic enter_circle);
		logic ent;
		logic can;
		ent = enter_circle ? m[BIT_CIRCLE] : m[BIT_CROSS];
		can = enter_circle ? m[BIT_CROSS] : m[BIT_CIRCLE];
		return {can, ent, m};
	endfunction

endpackage

// File: rtl/gert_if.sv
// Sample and result channel interfaces of the gamepad edge and repeat tracker.
interface gert_in_if import gert_pkg::*; ();
	logic valid;
	logic ready;
	logic [BUTTON_W-1:0] button_bits;
	logic [AXIS_W-1:0] left_x;
	logic [AXIS_W-1:0] left_y;
	logic [AXIS_W-1:0] right_x;
	logic [AXIS_W-1:0] right_y;
	logic sample_valid;
	logic end_of_poll;
	logic [TIME_W-1:0] time_now_us;

	modport source (output valid, button_bits, left_x, left_y, right_x, right_y,
		sample_valid, end_of_poll, time_now_us, input ready);
	modport sink (input valid, button_bits, left_x, left_y, right_x, right_y,
		sample_valid, end_of_poll, time_now_us, output ready);
endinterface

interface gert_out_if import gert_pkg::*; ();
	logic valid;
	logic ready;
	logic [MASK_W-1:0] held_mask;
	logic [MASK_W-1:0] prior_held_mask;
	logic [MASK_W-1:0] pressed_mask;
	logic [MASK_W-1:0] released_mask;
	logic [MASK_W-1:0] fast_repeat_mask;
	logic [MASK_W-1:0] slow_repeat_mask;
	logic [1:0] home_action;

	modport source (output valid, held_mask, prior_held_mask, pressed_mask, released_mask,
		fast_repeat_mask, slow_repeat_mask, home_action, input ready);
	modport sink (input valid, held_mask, prior_held_mask, pressed_mask, released_mask,
		fast_repeat_mask, slow_repeat_mask, home_action, output ready);
endinterface

// File: rtl/gamepad_edge_repeat_tracker.sv
// Gamepad edge and auto-repeat tracker: gathers port samples of a poll and reports
// held, edge and repeat masks plus a home-button action when the poll ends.
// One sample transaction is taken every clock cycle while the input register is not
// holding. A sample lands in the input register and is merged from there into the
// gathered mask; a sample that ends the poll also loads the result register as it
// leaves the input register, and the result is then offered. The input register
// holds only while a closing sample waits on a full result register whose transaction
// is not being taken.
module gamepad_edge_repeat_tracker import gert_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	gert_in_if.sink in_ch,
	gert_out_if.source out_ch
);

	logic [AXIS_W-1:0] center_q;
	logic [THR_W-1:0] threshold_q;
	logic enter_circle_q;
	logic [HOLD_W-1:0] home_hold_q;

	logic valid_s1;
	logic [BUTTON_W-1:0] buttons_s1;
	logic [AXIS_W-1:0] left_x_s1;
	logic [AXIS_W-1:0] left_y_s1;
	logic [AXIS_W-1:0] right_x_s1;
	logic [AXIS_W-1:0] right_y_s1;
	logic sample_valid_s1;
	logic eop_s1;
	logic [TIME_W-1:0] now_s1;

	logic [NBITS-1:0] gather_q;
	logic [NBITS-1:0] prev_q;
	logic [CNT_W-1:0] fast_cnt_q [NBITS];
	logic [CNT_W-1:0] slow_cnt_q [NBITS];
	logic [TIME_W-1:0] deadline_q;

	logic out_valid_q;
	logic [MASK_W-1:0] held_q;
	logic [MASK_W-1:0] prior_q;
	logic [MASK_W-1:0] pressed_q;
	logic [MASK_W-1:0] released_q;
	logic [MASK_W-1:0] fast_q;
	logic [MASK_W-1:0] slow_q;
	home_action_t action_q;

	logic out_free;
	logic take_s1;
	logic close_s1;
	logic [NBITS-1:0] sample;
	logic [NBITS-1:0] cur;
	logic [NBITS-1:0] pressed;
	logic [NBITS-1:0] released;
	logic [NBITS-1:0] fast;
	logic [NBITS-1:0] slow;
	logic [CNT_W-1:0] fast_cnt_d [NBITS];
	logic [CNT_W-1:0] slow_cnt_d [NBITS];
	home_action_t action;

	assign out_free = !out_valid_q || out_ch.ready;
	assign take_s1 = valid_s1 && (!eop_s1 || out_free);
	assign close_s1 = take_s1 && eop_s1;
	assign in_ch.ready = !valid_s1 || take_s1;

	always_comb begin
		sample = {axis_bits(right_y_s1, center_q, threshold_q),
			axis_bits(right_x_s1, center_q, threshold_q),
			axis_bits(left_y_s1, center_q, threshold_q),
			axis_bits(left_x_s1, center_q, threshold_q),
			buttons_s1};
		cur = sample_valid_s1 ? (gather_q | sample) : gather_q;
		pressed = cur & ~prev_q;
		released = ~cur & prev_q;
		fast = pressed;
		slow = pressed;
		for (int i = 0; i < NBITS; i++) begin
			fast_cnt_d[i] = '0;
			slow_cnt_d[i] = '0;
			if (cur[i]) begin
				if (fast_cnt_q[i] >= REPEAT_FIRE) begin
					fast[i] = 1'b1;
					fast_cnt_d[i] = FAST_RELOAD + CNT_W'(1);
				end else begin
					fast_cnt_d[i] = fast_cnt_q[i] + CNT_W'(1);
				end
				if (slow_cnt_q[i] >= REPEAT_FIRE) begin
					slow[i] = 1'b1;
					slow_cnt_d[i] = REPEAT_FIRE + CNT_W'(1);
				end else begin
					slow_cnt_d[i] = slow_cnt_q[i] + CNT_W'(1);
				end
			end
		end
		action = HOME_NONE;
		if (cur[BIT_HOME]) begin
			if (prev_q[BIT_HOME] && now_s1 >= deadline_q) begin
				action = HOME_DISABLE;
			end
		end else if (!prev_q[BIT_HOME]) begin
			action = HOME_ENABLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			threshold_q <= THRESHOLD_RST;
			enter_circle_q <= 1'b0;
			home_hold_q <= HOME_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER: center_q <= cfg_wdata[AXIS_W-1:0];
				REG_THRESHOLD: threshold_q <= cfg_wdata[THR_W-1:0];
				REG_ENTER_CIRCLE: enter_circle_q <= cfg_wdata[0];
				REG_HOME_HOLD: home_hold_q <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			buttons_s1 <= in_ch.button_bits;
			left_x_s1 <= in_ch.left_x;
			left_y_s1 <= in_ch.left_y;
			right_x_s1 <= in_ch.right_x;
			right_y_s1 <= in_ch.right_y;
			sample_valid_s1 <= in_ch.sample_valid;
			eop_s1 <= in_ch.end_of_poll;
			now_s1 <= in_ch.time_now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			prev_q <= '0;
			deadline_q <= '0;
			for (int i = 0; i < NBITS; i++) begin
				fast_cnt_q[i] <= '0;
				slow_cnt_q[i] <= '0;
			end
		end else if (take_s1) begin
			if (eop_s1) begin
				gather_q <= '0;
				prev_q <= cur;
				if (cur[BIT_HOME] && !prev_q[BIT_HOME]) begin
					deadline_q <= now_s1 + {{(TIME_W-HOLD_W){1'b0}}, home_hold_q};
				end
				for (int i = 0; i < NBITS; i++) begin
					fast_cnt_q[i] <= fast_cnt_d[i];
					slow_cnt_q[i] <= slow_cnt_d[i];
				end
			end else begin
				gather_q <= cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= close_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (close_s1) begin
			held_q <= add_mirror(cur, enter_circle_q);
			prior_q <= add_mirror(prev_q, enter_circle_q);
			pressed_q <= add_mirror(pressed, enter_circle_q);
			released_q <= add_mirror(released, enter_circle_q);
			fast_q <= add_mirror(fast, enter_circle_q);
			slow_q <= add_mirror(slow, enter_circle_q);
			action_q <= action;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.held_mask = held_q;
	assign out_ch.prior_held_mask = prior_q;
	assign out_ch.pressed_mask = pressed_q;
	assign out_ch.released_mask = released_q;
	assign out_ch.fast_repeat_mask = fast_q;
	assign out_ch.slow_repeat_mask = slow_q;
	assign out_ch.home_action = action_q;

endmodule

// File: rtl/gert_checker.sv
// Port-level checker of the gamepad edge and repeat tracker and its bind.
`include "gamepad_edge_repeat_tracker_assert.svh"

module gert_checker import gert_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [MASK_W-1:0] held,
	input logic [MASK_W-1:0] pressed,
	input logic [MASK_W-1:0] released,
	input logic [MASK_W-1:0] fast,
	input logic [MASK_W-1:0] slow
);

	`GERT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`GERT_ASSERT(a_edge_vs_held, !out_valid || ((pressed & ~held) == '0 && (released & held) == '0), "edge masks disagree with held mask")
	`GERT_ASSERT(a_fast_span, !out_valid || ((pressed & ~fast) == '0 && (fast & ~held) == '0), "fast repeat outside press and held")
	`GERT_ASSERT(a_slow_span, !out_valid || ((pressed & ~slow) == '0 && (slow & ~held) == '0), "slow repeat outside press and held")

endmodule

bind gamepad_edge_repeat_tracker gert_checker u_gert_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.held(out_ch.held_mask),
	.pressed(out_ch.pressed_mask),
	.released(out_ch.released_mask),
	.fast(out_ch.fast_repeat_mask),
	.slow(out_ch.slow_repeat_mask)
);
